// ----- rtl/lpd_pkg.sv -----
// shared constants and types for the 3x3 local peak detector
package lpd_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int THR_W      = 16;
  localparam int DIM_W      = 11;
  localparam int DIM_MIN    = 3;
  localparam int Q_DEPTH    = 4;
  localparam int WIN_TAPS   = 9;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT = 2'd2;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef struct packed {
    logic check;
    logic eof;
  } lpd_flags_t;

endpackage

// ----- rtl/lpd_front.sv -----
// front end: counters, line stores, window and per-sample classification
module lpd_front
  import lpd_pkg::*;
#(
  parameter int MAX_DIM     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  logic [$clog2(MAX_DIM):0]          row_count,
  input  logic [$clog2(MAX_DIM):0]          col_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              item_valid,
  input  logic                              item_ready,
  output lpd_flags_t                        item_flags,
  output logic [$clog2(MAX_DIM)-1:0]        item_row,
  output logic [$clog2(MAX_DIM)-1:0]        item_col,
  output logic [WIN_TAPS*SAMPLE_BITS-1:0]   item_win
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CNT_W = IDX_W + 1;

  logic [SAMPLE_BITS-1:0] line_a [MAX_DIM];
  logic [SAMPLE_BITS-1:0] line_b [MAX_DIM];

  logic [IDX_W-1:0]       row_r, col_r;
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [IDX_W-1:0]       s1_col_r;
  lpd_flags_t             s1_flags_r;
  logic [IDX_W-1:0]       s1_prow_r, s1_pcol_r;
  logic [SAMPLE_BITS-1:0] up_rd_r, upup_rd_r;
  logic [SAMPLE_BITS-1:0] win_r   [WIN_TAPS];
  logic [SAMPLE_BITS-1:0] win_nxt [WIN_TAPS];

  logic       accept, col_last, row_last, s1_keep, s1_go;
  lpd_flags_t flags_nxt;

  assign accept   = in_valid && in_ready;
  assign col_last = (CNT_W'(col_r) + CNT_W'(1)) >= col_count;
  assign row_last = (CNT_W'(row_r) + CNT_W'(1)) >= row_count;

  always_comb begin
    flags_nxt.check = (row_r >= IDX_W'(2)) && (col_r >= IDX_W'(2));
    flags_nxt.eof   = col_last && row_last;
  end

  assign s1_keep    = s1_flags_r.check || s1_flags_r.eof;
  assign s1_go      = s1_valid_r && (item_ready || !s1_keep);
  assign in_ready   = !s1_valid_r || s1_go;
  assign item_valid = s1_valid_r && s1_keep;
  assign item_flags = s1_flags_r;
  assign item_row   = s1_prow_r;
  assign item_col   = s1_pcol_r;

  // scan position
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + IDX_W'(1);
      end else begin
        col_r <= col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_flags_r  <= flags_nxt;
      s1_prow_r   <= row_r - IDX_W'(1);
      s1_pcol_r   <= col_r - IDX_W'(1);
    end
  end

  // line stores: read on accept, written back when the sample leaves stage one
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r   <= line_a[col_r];
      upup_rd_r <= line_b[col_r];
    end
    if (s1_go) begin
      line_a[s1_col_r] <= s1_sample_r;
      line_b[s1_col_r] <= up_rd_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3+1];
      win_nxt[i*3 + 1] = win_r[i*3+2];
    end
    win_nxt[2] = upup_rd_r;
    win_nxt[5] = up_rd_r;
    win_nxt[8] = s1_sample_r;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < WIN_TAPS; k++) begin
      item_win[k*SAMPLE_BITS +: SAMPLE_BITS] = win_nxt[k];
    end
  end

endmodule

// ----- rtl/lpd_fifo.sv -----
// short request queue between front end and peak decision
module lpd_fifo
  import lpd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> pop_valid) else $error("pop from empty queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with split pointers");
`endif

endmodule

// ----- rtl/lpd_back.sv -----
// back end: neighbourhood compare and result output register
module lpd_back
  import lpd_pkg::*;
#(
  parameter int MAX_DIM     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [THR_W-1:0]           threshold,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  lpd_flags_t                        q_flags,
  input  logic [$clog2(MAX_DIM)-1:0]        q_row,
  input  logic [$clog2(MAX_DIM)-1:0]        q_col,
  input  logic [WIN_TAPS*SAMPLE_BITS-1:0]   q_win,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [$clog2(MAX_DIM)-1:0]        out_row,
  output logic [$clog2(MAX_DIM)-1:0]        out_col,
  output logic [SAMPLE_BITS-1:0]            out_value
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic signed [SAMPLE_BITS-1:0] nb [WIN_TAPS];
  logic signed [CMP_W-1:0]       ctr_ext, thr_ext;

  logic                   out_valid_r, out_kind_r, eof_pend_r;
  logic [IDX_W-1:0]       out_row_r, out_col_r;
  logic [SAMPLE_BITS-1:0] out_value_r;

  logic is_peak, slot_free, emit_peak, emit_eof, load;

  always_comb begin
    for (int k = 0; k < WIN_TAPS; k++) begin
      nb[k] = q_win[k*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  assign ctr_ext = CMP_W'(nb[4]);
  assign thr_ext = CMP_W'(threshold);

  // strict on the left column and above, non-strict on the right column and below
  assign is_peak = (ctr_ext > thr_ext)
                && (nb[4] >  nb[0]) && (nb[4] >  nb[3]) && (nb[4] >  nb[6])
                && (nb[4] >  nb[1]) && (nb[4] >= nb[7]) && (nb[4] >= nb[2])
                && (nb[4] >= nb[5]) && (nb[4] >= nb[8]);

  assign slot_free = !out_valid_r || out_ready;
  assign emit_peak = q_valid && q_flags.check && is_peak && !eof_pend_r;
  assign emit_eof  = q_valid && q_flags.eof && (eof_pend_r || !(q_flags.check && is_peak));
  assign load      = slot_free && (emit_peak || emit_eof);
  assign q_pop     = q_valid && ((load && !(emit_peak && q_flags.eof))
                              || (!emit_peak && !emit_eof));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      eof_pend_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        eof_pend_r <= 1'b0;
      end else if (load && emit_peak && q_flags.eof) begin
        eof_pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_peak) begin
        out_kind_r  <= KIND_PEAK;
        out_row_r   <= q_row;
        out_col_r   <= q_col;
        out_value_r <= nb[4];
      end else begin
        out_kind_r  <= KIND_EOF;
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_value_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_pend_has_eof: assert property (@(posedge clk) disable iff (!rst_n)
    eof_pend_r |-> (q_valid && q_flags.eof)) else $error("pending marker without frame end");

  a_pend_after_peak: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(eof_pend_r) |-> (out_valid_r && out_kind_r == KIND_PEAK))
    else $error("marker pending without a peak ahead of it");

  a_eof_leaves_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_flags.eof) |=> (out_valid_r && out_kind_r == KIND_EOF))
    else $error("frame end retired without a marker");
`endif

endmodule

// ----- rtl/local_peak_detect_3x3.sv -----
// top level: configuration registers and 3x3 local peak detector
//
//  channel  dir  handshake                   payload
//  in_      in   in_tvalid / in_tready       in_tdata: sample
//  out_     out  out_tvalid / out_tready     out_tuser: kind; out_tdata: row, col, value
//  cfg_     in   apb write when psel&penable threshold, row_count, col_count
//
// one sample per clock sustained while out_tready stays high; a frame end with a final peak emits a peak
// and then a frame-end marker, taken up by the four-entry queue between front and back
// reset: counters and handshakes clear at once; line stores hold no reset and need no sweep
// stalls: out_tready low fills the output register, then the queue, then in_tready drops
module local_peak_detect_3x3
  import lpd_pkg::*;
#(
  parameter int MAX_DIM     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,    // sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((2 * $clog2(MAX_DIM) + SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
                                                   // peak_row, peak_col, peak_value
  output logic                  out_tuser,         // kind
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CLW     = (DIM_W > CNT_W) ? DIM_W : CNT_W;
  localparam int OUT_PAY = 2 * IDX_W + SAMPLE_BITS;
  localparam int OUT_W   = ((OUT_PAY + 7) / 8) * 8;
  localparam int WIN_W   = WIN_TAPS * SAMPLE_BITS;
  localparam int Q_W     = 2 + 2 * IDX_W + WIN_W;

  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] row_cnt_r, col_cnt_r;
  logic             cfg_wr, restart;
  logic [1:0]       reg_sel;
  logic [CLW-1:0]   dim_ext;
  logic [CNT_W-1:0] dim_clamped;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign restart    = cfg_wr && (reg_sel == REG_ROW_COUNT || reg_sel == REG_COL_COUNT);
  assign dim_ext    = CLW'(cfg_pwdata[DIM_W-1:0]);

  always_comb begin
    if (dim_ext < CLW'(DIM_MIN)) begin
      dim_clamped = CNT_W'(DIM_MIN);
    end else if (dim_ext > CLW'(MAX_DIM)) begin
      dim_clamped = CNT_W'(MAX_DIM);
    end else begin
      dim_clamped = CNT_W'(dim_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      row_cnt_r <= CNT_W'(64);
      col_cnt_r <= CNT_W'(64);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_THRESHOLD: thr_r     <= cfg_pwdata[THR_W-1:0];
        REG_ROW_COUNT: row_cnt_r <= dim_clamped;
        REG_COL_COUNT: col_cnt_r <= dim_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_ROW_COUNT: cfg_prdata = CFG_DATA_W'(row_cnt_r);
      REG_COL_COUNT: cfg_prdata = CFG_DATA_W'(col_cnt_r);
      default:       cfg_prdata = '0;
    endcase
  end

  logic             f_valid, f_ready;
  lpd_flags_t       f_flags;
  logic [IDX_W-1:0] f_row, f_col;
  logic [WIN_W-1:0] f_win;

  lpd_front #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .row_count  (row_cnt_r),
    .col_count  (col_cnt_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_flags (f_flags),
    .item_row   (f_row),
    .item_col   (f_col),
    .item_win   (f_win)
  );

  logic           q_valid, q_pop;
  logic [Q_W-1:0] q_head;

  lpd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_flags, f_row, f_col, f_win}),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_head)
  );

  logic [IDX_W-1:0]       o_row, o_col;
  logic [SAMPLE_BITS-1:0] o_value;

  lpd_back #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_flags   (lpd_flags_t'(q_head[Q_W-1 -: 2])),
    .q_row     (q_head[WIN_W + IDX_W +: IDX_W]),
    .q_col     (q_head[WIN_W +: IDX_W]),
    .q_win     (q_head[WIN_W-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_row   (o_row),
    .out_col   (o_col),
    .out_value (o_value)
  );

  assign out_tdata = OUT_W'({o_value, o_col, o_row});

endmodule
